// ===== rtl/core/sis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types, codes and defaults for the sorted insert stack.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned DataWidthDef  = 32;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FillW  = 5;

  // returned by a pop on an empty stack
  localparam logic [ValueW-1:0] EmptyPopCode = -32'sd999;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_REVERSE = 2'd2,
    FUNC_INSERT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_WAIT,
    ST_REV_HI,
    ST_REV_WLO,
    ST_REV_WHI,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
    logic              empty;
    logic              full;
    logic [FillW-1:0]  fill;
  } res_t;

endpackage : sis_pkg
`default_nettype wire

// ===== rtl/core/sis_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sis_mem #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output      logic [DATA_WIDTH-1:0] rd_data_o,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [DATA_WIDTH-1:0] wr_data_i
);

  logic [DATA_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : sis_mem
`default_nettype wire

// ===== rtl/core/sis_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_outbuf
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module sis_outbuf
  import sis_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  output      logic                res_ready_o,
  input  wire res_t                res_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [ValueW-1:0]   result_value_o,
  output      logic [1:0]          status_o,
  output      logic                is_empty_o,
  output      logic                is_full_o,
  output      logic [FillW-1:0]    fill_count_o
);

  logic out_valid_q, out_valid_d;
  res_t res_q;
  logic load;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q.value;
  assign status_o       = res_q.status;
  assign is_empty_o     = res_q.empty;
  assign is_full_o      = res_q.full;
  assign fill_count_o   = res_q.fill;

endmodule : sis_outbuf
`default_nettype wire

// ===== rtl/core/sis_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ctrl
// Operation sequencer: fill count, read-modify-write walks over the store.
// ----------------------------------------------------------------------------
module sis_ctrl
  import sis_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned DATA_WIDTH  = DataWidthDef,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [ValueW-1:0]     value_i,
  output      logic                  mem_re_o,
  output      logic [AW-1:0]         mem_ra_o,
  input  wire logic [DATA_WIDTH-1:0] mem_rd_i,
  output      logic                  mem_we_o,
  output      logic [AW-1:0]         mem_wa_o,
  output      logic [DATA_WIDTH-1:0] mem_wd_o,
  output      logic                  res_valid_o,
  input  wire logic                  res_ready_i,
  output      res_t                  res_o
);

  state_e                state_q, state_d;
  func_e                 func_q, func_d;
  logic [DATA_WIDTH-1:0] x_q, x_d;
  logic [DATA_WIDTH-1:0] tmp_q, tmp_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         lo_q, lo_d;
  logic [AW-1:0]         hi_q, hi_d;
  logic [ValueW-1:0]     rval_q, rval_d;
  status_e               rstat_q, rstat_d;

  logic [63:0]           val_ext;
  logic [63:0]           rd_ext;
  logic [31:0]           cnt_ext;
  logic                  full, empty;
  logic [AW-1:0]         top;
  logic                  le;

  // low DATA_WIDTH bits of the input word; zero-extended above 32 bits
  assign val_ext = {32'b0, value_i};
  assign rd_ext  = 64'(signed'(mem_rd_i));
  assign cnt_ext = 32'(count_q);

  assign full  = (count_q == CW'(STACK_DEPTH));
  assign empty = (count_q == '0);
  assign top   = count_q[AW-1:0];
  assign le    = $signed(mem_rd_i) <= $signed(x_q);

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    x_d      = x_q;
    tmp_d    = tmp_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    rval_d   = rval_q;
    rstat_d  = rstat_q;
    mem_re_o = 1'b0;
    mem_ra_o = '0;
    mem_we_o = 1'b0;
    mem_wa_o = '0;
    mem_wd_o = x_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d  = func_e'(func_i);
          x_d     = val_ext[DATA_WIDTH-1:0];
          rval_d  = '0;
          rstat_d = STAT_DONE;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        unique case (func_q)
          FUNC_PUSH: begin
            if (full) begin
              rstat_d = STAT_FULL;
            end else begin
              mem_we_o = 1'b1;
              mem_wa_o = top;
              count_d  = count_q + CW'(1);
            end
          end
          FUNC_POP: begin
            if (empty) begin
              rval_d  = EmptyPopCode;
              rstat_d = STAT_EMPTY;
            end else begin
              mem_re_o = 1'b1;
              mem_ra_o = top - AW'(1);
              count_d  = count_q - CW'(1);
              state_d  = ST_POP_WAIT;
            end
          end
          FUNC_REVERSE: begin
            if (empty) begin
              rstat_d = STAT_EMPTY;
            end else if (count_q != CW'(1)) begin
              lo_d     = '0;
              hi_d     = top - AW'(1);
              mem_re_o = 1'b1;
              mem_ra_o = '0;
              state_d  = ST_REV_HI;
            end
          end
          FUNC_INSERT: begin
            if (full) begin
              rstat_d = STAT_FULL;
            end else begin
              count_d = count_q + CW'(1);
              lo_d    = top;
              if (empty) begin
                mem_we_o = 1'b1;
                mem_wa_o = '0;
              end else begin
                mem_re_o = 1'b1;
                mem_ra_o = top - AW'(1);
                state_d  = ST_INS_CMP;
              end
            end
          end
        endcase
      end
      ST_POP_WAIT: begin
        rval_d  = rd_ext[ValueW-1:0];
        state_d = ST_RESP;
      end
      ST_REV_HI: begin
        tmp_d    = mem_rd_i;
        mem_re_o = 1'b1;
        mem_ra_o = hi_q;
        state_d  = ST_REV_WLO;
      end
      ST_REV_WLO: begin
        mem_we_o = 1'b1;
        mem_wa_o = lo_q;
        mem_wd_o = mem_rd_i;
        state_d  = ST_REV_WHI;
      end
      ST_REV_WHI: begin
        mem_we_o = 1'b1;
        mem_wa_o = hi_q;
        mem_wd_o = tmp_q;
        lo_d     = lo_q + AW'(1);
        hi_d     = hi_q - AW'(1);
        if ((lo_q + AW'(1)) < (hi_q - AW'(1))) begin
          mem_re_o = 1'b1;
          mem_ra_o = lo_q + AW'(1);
          state_d  = ST_REV_HI;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_INS_CMP: begin
        // read data is the entry just below slot lo_q
        mem_we_o = 1'b1;
        mem_wa_o = lo_q;
        if (le) begin
          mem_wd_o = mem_rd_i;
          lo_d     = lo_q - AW'(1);
          if (lo_q == AW'(1)) begin
            state_d = ST_INS_FIN;
          end else begin
            mem_re_o = 1'b1;
            mem_ra_o = lo_q - AW'(2);
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_INS_FIN: begin
        mem_we_o = 1'b1;
        mem_wa_o = lo_q;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.value  = rval_q;
    res_o.status = rstat_q;
    res_o.empty  = empty;
    res_o.full   = full;
    res_o.fill   = cnt_ext[FillW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    x_q     <= x_d;
    tmp_q   <= tmp_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    rval_q  <= rval_d;
    rstat_q <= rstat_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("fill count above depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_wa_o != mem_ra_o))
    else $error("read and write to the same entry in one cycle");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && func_q == FUNC_PUSH && !full)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not bump the fill count");

  a_ins_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_CMP) |-> (lo_q != '0))
    else $error("insert walk below the bottom entry");
`endif

endmodule : sis_ctrl
`default_nettype wire

// ===== rtl/core/sorted_insert_stack_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_stack_top
// Bounded stack of signed words with push, pop, reverse and sorted insert.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries func_i and value_i; output
// channel (out_valid_o/out_ready_i) returns one result per input transfer:
// popped word (EmptyPopCode if empty) or zero, status, empty/full flags
// and fill count. One item is worked at a time; the entries live in a
// single-port-read, single-port-write memory with registered read data.
// Sorted insert walks one entry per cycle through the memory port.
// A new input is taken from the cycle after the previous result enters the
// output register, even while that result waits on out_ready_i.
// Reset empties the stack at once; no clearing pass is run. A stalled
// receiver holds the result register; a further finished result waits in
// the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module sorted_insert_stack_top
  import sis_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef,
  parameter int unsigned DATA_WIDTH  = DataWidthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic [1:0]               func_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [ValueW-1:0] result_value_o,
  output      logic [1:0]               status_o,
  output      logic                     is_empty_o,
  output      logic                     is_full_o,
  output      logic [FillW-1:0]         fill_count_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_ra, mem_wa;
  logic [DATA_WIDTH-1:0] mem_rd, mem_wd;
  logic                  res_valid, res_ready;
  res_t                  res;

  sis_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_ra),
    .rd_data_o (mem_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_wa),
    .wr_data_i (mem_wd)
  );

  sis_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .mem_re_o    (mem_re),
    .mem_ra_o    (mem_ra),
    .mem_rd_i    (mem_rd),
    .mem_we_o    (mem_we),
    .mem_wa_o    (mem_wa),
    .mem_wd_o    (mem_wd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  sis_outbuf u_outbuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .fill_count_o   (fill_count_o)
  );

endmodule : sorted_insert_stack_top
`default_nettype wire
